### hw/rtl/assert_macros.svh
// Assertion macros used by the RTL of the prefix varint codec.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

### hw/rtl/pvc_pkg.sv
// Types, constants and helper functions of the prefix varint codec.
package pvc_pkg;

  localparam int PVC_VALUE_W     = 64;
  localparam int PVC_BYTE_W      = 8;
  localparam int PVC_LEN_W       = 4;
  localparam int PVC_MAX_LEN     = 9;
  localparam int PVC_GROUP_BITS  = 7;
  localparam int PVC_QUEUE_DEPTH = 2;
  localparam int PVC_S_DATA_W    = 72;
  localparam int PVC_M_DATA_W    = 80;

  typedef enum logic {
    PVC_ENC = 1'b0,
    PVC_DEC = 1'b1
  } pvc_kind_t;

  typedef struct packed {
    pvc_kind_t              kind;
    logic [PVC_VALUE_W-1:0] value;
    logic [PVC_LEN_W-1:0]   len;
  } pvc_cmd_t;

  // encoded length: one more byte for every 7-bit group above the first, up to the highest group that holds a one
  function automatic logic [PVC_LEN_W-1:0] enc_length(input logic [PVC_VALUE_W-1:0] v);
    logic [PVC_LEN_W-1:0] len;
    len = PVC_LEN_W'(1);
    for (int k = 1; k < PVC_MAX_LEN; k++) begin
      if ((v >> (PVC_GROUP_BITS * k)) != '0) len = len + PVC_LEN_W'(1);
    end
    return len;
  endfunction

  // run length from the leading ones of the first byte
  function automatic logic [PVC_LEN_W-1:0] dec_length(input logic [PVC_BYTE_W-1:0] b);
    logic [PVC_LEN_W-1:0] k;
    logic                 run;
    k   = '0;
    run = 1'b1;
    for (int i = PVC_BYTE_W - 1; i >= 0; i--) begin
      run = run & b[i];
      if (run) k = k + PVC_LEN_W'(1);
    end
    return k + PVC_LEN_W'(1);
  endfunction

  function automatic logic [PVC_VALUE_W-1:0] dec_mask(input logic [PVC_LEN_W-1:0] len);
    logic [6:0] sh;
    sh = 7'(len) * 7'(PVC_GROUP_BITS);
    if (len >= PVC_LEN_W'(PVC_MAX_LEN)) return '1;
    return ~({PVC_VALUE_W{1'b1}} << sh);
  endfunction

  // length marker ORed into the first encoded byte
  function automatic logic [PVC_BYTE_W-1:0] enc_marker(input logic [PVC_LEN_W-1:0] len);
    logic [PVC_BYTE_W-1:0] m;
    case (len)
      4'd2:    m = 8'h80;
      4'd3:    m = 8'hC0;
      4'd4:    m = 8'hE0;
      4'd5:    m = 8'hF0;
      4'd6:    m = 8'hF8;
      4'd7:    m = 8'hFC;
      4'd8:    m = 8'hFE;
      4'd9:    m = 8'hFF;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

### hw/rtl/prefix_varint_codec_top.sv
// Top level of the prefix varint codec: front end, command queue, back end.
//
// Input stream: s_tuser selects encode (0) or decode (1). An encode takes
// value_in and gives 1 to 9 byte transfers, big-endian, the first carrying
// the length marker; tlast flags the final byte. A decode takes one byte per
// transfer and gives one value transfer, with its run length, when the run
// completes; bytes inside a run give nothing.
// A request's first result goes through a queue entry and then the output
// register. The front end takes a new transfer whenever the queue is not full;
// the back end emits an encode's bytes (1 to 9) one byte per cycle from the
// queue head while the receiver is ready. A two-entry queue lets the front
// take further input while the back end is still emitting.
// When the receiver stalls the output register holds, the queue fills and
// s_tready falls once it is full.
// Reset (rst, synchronous) empties the queue, drops m_tvalid and clears the
// decode run state.
`include "assert_macros.svh"

module prefix_varint_codec_top
  import pvc_pkg::*;
#(
  parameter int QUEUE_DEPTH = PVC_QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [PVC_S_DATA_W-1:0] s_tdata,   // value_in[63:0], byte_in[71:64]
  input  logic                    s_tuser,   // req_type
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [PVC_M_DATA_W-1:0] m_tdata,   // byte_out[7:0], value_out[71:8],
                                             // run_length[75:72], zero[79:76]
  output logic                    m_tuser,   // result_kind
  output logic                    m_tlast    // is_last
);

  logic                 q_push;
  logic                 q_pop;
  logic                 q_full;
  logic                 q_empty;
  pvc_cmd_t             q_cmd;
  pvc_cmd_t             q_head;
  logic [PVC_LEN_W-1:0] m_len;

  assign m_len = m_tdata[75:72];

  pvc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  pvc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  pvc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  `ASSERT_IMPL(a_no_push_full, clk, rst, q_push, !q_full, "push into full queue")
  `ASSERT_IMPL(a_dec_single, clk, rst, m_tvalid && m_tuser == PVC_DEC, m_tlast, "decode not last")
  `ASSERT_IMPL(a_len_range, clk, rst, m_tvalid, m_len != 4'd0 && m_len <= 4'd9, "bad length")
  `ASSERT_NEXT(a_pop_shows, clk, rst, q_pop, m_tvalid, "popped command not shown")

endmodule

### hw/rtl/pvc_front.sv
// Front end: takes requests, sizes encodes, tracks decode runs, feeds the queue.
module pvc_front
  import pvc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [PVC_S_DATA_W-1:0] s_tdata,
  input  logic                    s_tuser,
  input  logic                    q_full,
  output logic                    q_push,
  output pvc_cmd_t                q_cmd
);

  logic [PVC_LEN_W-1:0]   bytes_seen;
  logic [PVC_LEN_W-1:0]   exp_len;
  logic [PVC_VALUE_W-1:0] acc;

  logic [PVC_LEN_W-1:0]   bytes_seen_next;
  logic [PVC_LEN_W-1:0]   exp_len_next;
  logic [PVC_VALUE_W-1:0] acc_next;

  logic                   accept;
  logic                   done;
  pvc_kind_t              req;
  logic [PVC_VALUE_W-1:0] value_in;
  logic [PVC_BYTE_W-1:0]  byte_in;

  assign req      = pvc_kind_t'(s_tuser);
  assign value_in = s_tdata[PVC_VALUE_W-1:0];
  assign byte_in  = s_tdata[PVC_VALUE_W +: PVC_BYTE_W];
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    if (bytes_seen == '0) begin
      acc_next        = {{(PVC_VALUE_W-PVC_BYTE_W){1'b0}}, byte_in};
      bytes_seen_next = PVC_LEN_W'(1);
      exp_len_next    = dec_length(byte_in);
    end else begin
      acc_next        = {acc[PVC_VALUE_W-PVC_BYTE_W-1:0], byte_in};
      bytes_seen_next = bytes_seen + PVC_LEN_W'(1);
      exp_len_next    = exp_len;
    end
    done = bytes_seen_next >= exp_len_next;
  end

  assign q_push = accept && (req == PVC_ENC || done);

  always_comb begin
    q_cmd.kind = req;
    if (req == PVC_ENC) begin
      q_cmd.value = value_in;
      q_cmd.len   = enc_length(value_in);
    end else begin
      q_cmd.value = acc_next & dec_mask(exp_len_next);
      q_cmd.len   = exp_len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      exp_len    <= '0;
      acc        <= '0;
    end else if (accept && req == PVC_DEC) begin
      bytes_seen <= done ? '0 : bytes_seen_next;
      exp_len    <= exp_len_next;
      acc        <= acc_next;
    end
  end

endmodule

### hw/rtl/pvc_queue.sv
// Short command queue between front and back end.
module pvc_queue
  import pvc_pkg::*;
#(
  parameter int DEPTH = PVC_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  pvc_cmd_t push_cmd,
  input  logic     pop,
  output pvc_cmd_t head,
  output logic     full,
  output logic     empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  pvc_cmd_t         entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(DEPTH);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

endmodule

### hw/rtl/pvc_back.sv
// Back end: turns queued commands into result transfers through the output register.
module pvc_back
  import pvc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  pvc_cmd_t                head,
  input  logic                    q_empty,
  output logic                    q_pop,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [PVC_M_DATA_W-1:0] m_tdata,
  output logic                    m_tuser,
  output logic                    m_tlast
);

  logic [PVC_LEN_W-1:0]  idx;
  logic [PVC_LEN_W-1:0]  pos;
  logic                  load;
  logic                  last;
  logic [PVC_BYTE_W-1:0] byte_sel;
  logic [PVC_BYTE_W-1:0] byte_out;
  logic [PVC_VALUE_W-1:0] value_out;

  assign load  = !q_empty && (!m_tvalid || m_tready);
  assign last  = head.kind == PVC_DEC || idx == head.len - PVC_LEN_W'(1);
  assign q_pop = load && last;
  assign pos   = head.len - PVC_LEN_W'(1) - idx;

  always_comb begin
    byte_sel = pos[3] ? '0 : head.value[{pos[2:0], 3'b000} +: PVC_BYTE_W];
    if (idx == '0) byte_sel = byte_sel | enc_marker(head.len);
    if (head.kind == PVC_ENC) begin
      byte_out  = byte_sel;
      value_out = '0;
    end else begin
      byte_out  = '0;
      value_out = head.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= '0;
    end else begin
      if (load)          m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (load) idx <= last ? '0 : idx + PVC_LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {{(PVC_M_DATA_W-PVC_LEN_W-PVC_VALUE_W-PVC_BYTE_W){1'b0}},
                  head.len, value_out, byte_out};
      m_tuser <= head.kind;
      m_tlast <= last;
    end
  end

endmodule
